// ===== hw/rtl/dcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcd_pkg: shared types and constants for day count to calendar date
// Epoch constants, month length table, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package dcd_pkg;

    localparam int unsigned COUNT_W = 16;
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MIDX_W  = 4;

    localparam int unsigned EPOCH_YEAR     = 1978;
    localparam int unsigned NORM_YEAR_LEN  = 365;
    localparam int unsigned LEAP_YEAR_LEN  = 366;
    localparam int unsigned LEAP_CYCLE     = 4;
    localparam int unsigned CENTURY        = 100;
    localparam int unsigned QUAD_CENTURY   = 400;
    localparam int unsigned LEAP_FEB_LEN   = 29;
    localparam int unsigned LAST_MONTH_IDX = 11;

    // residues of the epoch year, used to seed the leap counters
    localparam int unsigned EPOCH_MOD4   = EPOCH_YEAR % LEAP_CYCLE;
    localparam int unsigned EPOCH_MOD100 = EPOCH_YEAR % CENTURY;
    localparam int unsigned EPOCH_MOD400 = EPOCH_YEAR % QUAD_CENTURY;

    localparam int unsigned M4_W   = 2;
    localparam int unsigned M100_W = 7;
    localparam int unsigned M400_W = 9;

    typedef enum logic [1:0] {
        S_IDLE,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic year_step;
        logic month_step;
        logic capture;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic year_ge;
        logic month_ge;
    } t_sts;

    // days in month; index 0 is january
    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MIDX_W-1:0] idx);
        logic [DAY_W-1:0] len;
        case (idx)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = DAY_W'(31);
            4'd3, 4'd5, 4'd8, 4'd10:                   len = DAY_W'(30);
            4'd1: len = leap ? DAY_W'(LEAP_FEB_LEN) : DAY_W'(LEAP_FEB_LEN - 1);
            default:                                   len = DAY_W'(31);
        endcase
        return len;
    endfunction

endpackage

// ===== hw/rtl/dcd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcd_if: valid/ready channels of the day count converter
// Input channel carries the day count, output channel the calendar date.
// ----------------------------------------------------------------------------
interface dcd_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] day_count;

    modport source (output valid, output day_count, input ready);
    modport sink   (input valid, input day_count, output ready);
endinterface

interface dcd_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;

    modport source (output valid, output year, output month, output day, input ready);
    modport sink   (input valid, input year, input month, input day, output ready);
endinterface

// ===== hw/rtl/dcd_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcd_dp: datapath of the day count converter
// Holds the remaining day count, the year with its leap residues, the
// month index and the output register.
// ----------------------------------------------------------------------------
module dcd_dp (
    input  logic                          i_clk,
    input  dcd_pkg::t_cmd                 i_cmd,
    input  logic [dcd_pkg::COUNT_W-1:0]   i_day_count,
    output dcd_pkg::t_sts                 o_sts,
    output logic [dcd_pkg::YEAR_W-1:0]    o_year,
    output logic [dcd_pkg::MONTH_W-1:0]   o_month,
    output logic [dcd_pkg::DAY_W-1:0]     o_day
);
    import dcd_pkg::*;

    logic [COUNT_W-1:0] r_rem,  n_rem;
    logic [YEAR_W-1:0]  r_year, n_year;
    logic [M4_W-1:0]    r_m4,   n_m4;
    logic [M100_W-1:0]  r_m100, n_m100;
    logic [M400_W-1:0]  r_m400, n_m400;
    logic [MIDX_W-1:0]  r_midx, n_midx;
    logic               r_zero, n_zero;
    logic [YEAR_W-1:0]  r_out_year;
    logic [MONTH_W-1:0] r_out_month;
    logic [DAY_W-1:0]   r_out_day;

    logic               leap;
    logic [COUNT_W-1:0] year_len;
    logic [DAY_W-1:0]   mlen;

    // leap rule from the running residues
    assign leap     = ((r_m4 == '0) && (r_m100 != '0)) || (r_m400 == '0);
    assign year_len = leap ? COUNT_W'(LEAP_YEAR_LEN) : COUNT_W'(NORM_YEAR_LEN);
    assign mlen     = month_len(leap, r_midx);

    // status to the controller
    assign o_sts.zero     = r_zero;
    assign o_sts.year_ge  = (r_rem >= year_len);
    assign o_sts.month_ge = (r_midx < MIDX_W'(LAST_MONTH_IDX))
                            && (r_rem >= COUNT_W'(mlen));

    // working register updates
    always_comb begin
        n_rem  = r_rem;
        n_year = r_year;
        n_m4   = r_m4;
        n_m100 = r_m100;
        n_m400 = r_m400;
        n_midx = r_midx;
        n_zero = r_zero;
        if (i_cmd.load) begin
            n_rem  = i_day_count - COUNT_W'(1);
            n_year = YEAR_W'(EPOCH_YEAR);
            n_m4   = M4_W'(EPOCH_MOD4);
            n_m100 = M100_W'(EPOCH_MOD100);
            n_m400 = M400_W'(EPOCH_MOD400);
            n_midx = '0;
            n_zero = (i_day_count == '0);
        end else if (i_cmd.year_step) begin
            n_rem  = r_rem - year_len;
            n_year = r_year + YEAR_W'(1);
            n_m4   = r_m4 + M4_W'(1);
            n_m100 = (r_m100 == M100_W'(CENTURY - 1)) ? '0 : r_m100 + M100_W'(1);
            n_m400 = (r_m400 == M400_W'(QUAD_CENTURY - 1)) ? '0 : r_m400 + M400_W'(1);
        end else if (i_cmd.month_step) begin
            n_rem  = r_rem - COUNT_W'(mlen);
            n_midx = r_midx + MIDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_year <= n_year;
        r_m4   <= n_m4;
        r_m100 <= n_m100;
        r_m400 <= n_m400;
        r_midx <= n_midx;
        r_zero <= n_zero;
    end

    // output register, zero date for a zero count
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_out_year  <= r_zero ? '0 : r_year;
            r_out_month <= r_zero ? '0 : MONTH_W'(r_midx + MIDX_W'(1));
            r_out_day   <= r_zero ? '0 : DAY_W'(r_rem[DAY_W-1:0] + DAY_W'(1));
        end
    end

    assign o_year  = r_out_year;
    assign o_month = r_out_month;
    assign o_day   = r_out_day;

endmodule

// ===== hw/rtl/dcd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcd_ctrl: controller of the day count converter
// Sequences load, year subtraction, month subtraction and hand-off to
// the output register; owns the handshake flags.
// ----------------------------------------------------------------------------
module dcd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  dcd_pkg::t_sts i_sts,
    output dcd_pkg::t_cmd o_cmd
);
    import dcd_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // output register may be loaded when empty or being drained
    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_YEAR;
            end
            S_YEAR: begin
                if (i_sts.zero) n_state = S_DONE;
                else if (!i_sts.year_ge) n_state = S_MONTH;
            end
            S_MONTH: begin
                if (!i_sts.month_ge) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_YEAR: begin
                o_cmd.year_step = !i_sts.zero && i_sts.year_ge;
            end
            S_MONTH: begin
                o_cmd.month_step = i_sts.month_ge;
            end
            S_DONE: begin
                o_cmd.capture = out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.capture) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/day_count_to_calendar_date.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// day_count_to_calendar_date: day count to Gregorian date converter
// Turns a 16-bit day count (1 = 1 January 1978) into year, month, day.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries day_count; a transaction completes when valid and ready
//   are both high. o_out carries year, month and day with the same rule.
//   ready on i_in is high only while the converter is idle.
// Sequence:
//   load the count, subtract whole years one at a time (up to 179), then
//   whole months one at a time (up to 11), leave each loop and write the
//   output register. The year subtraction loop dominates the conversion
//   time. A count of 0 skips both loops and gives a zero date. A new day
//   count is taken only after the last one is written to the output
//   register.
// Stalls:
//   the result sits in an output register; the next transaction is taken
//   and converted while it waits, and the converter holds at the end of
//   that conversion until the output register is drained.
// Reset:
//   synchronous, active low; clears the controller and the output valid.
// ----------------------------------------------------------------------------
module day_count_to_calendar_date (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dcd_in_if.sink    i_in,
    dcd_out_if.source o_out
);
    import dcd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // controller
    dcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath
    dcd_dp u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_day_count (i_in.day_count),
        .o_sts       (sts),
        .o_year      (o_out.year),
        .o_month     (o_out.month),
        .o_day       (o_out.day)
    );

    // a date is either all zero or all fields present
    a_zero_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.year == '0) == (o_out.month == '0))
                        && ((o_out.month == '0) == (o_out.day == '0)))
        else $error("partial zero date");

    // a real date lies in range
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.month != '0) |->
            (o_out.month <= MONTH_W'(12)) && (o_out.day != '0)
            && (o_out.year >= YEAR_W'(EPOCH_YEAR)))
        else $error("date out of range");

    // february never exceeds the leap length
    a_feb_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.month == MONTH_W'(2)) |->
            (o_out.day <= DAY_W'(LEAP_FEB_LEN)))
        else $error("february day too large");

    // no input taken while a step is in progress
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.year_step || cmd.month_step || cmd.capture) |-> !i_in.ready)
        else $error("input ready during conversion");

endmodule
